// File: rtl/jalali_gregorian_date_convert_defines.svh
// Assertion helpers for the date converter checkers.
`ifndef JALALI_GREGORIAN_DATE_CONVERT_DEFINES_SVH
`define JALALI_GREGORIAN_DATE_CONVERT_DEFINES_SVH

// Checked only while reset is low.
`define JGDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define JGDC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/jgdc_pkg.sv
`timescale 1ns / 1ps
package jgdc_pkg;

   localparam int NUM_STAGES = 14;

   typedef logic [NUM_STAGES-1:0] stage_en_type;

   typedef enum logic {
      OP_GREG_TO_JAL = 1'b0,
      OP_JAL_TO_GREG = 1'b1
   } op_type;

   typedef enum logic {
      CSR_MIN_JALALI_YEAR = 1'b0,
      CSR_MAX_JALALI_YEAR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [14:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic        invalid;
   } result_type;

   localparam logic [13:0] MIN_YEAR_RESET = 14'd1131;
   localparam logic [13:0] MAX_YEAR_RESET = 14'd10000;

   localparam int CYCLE_DAYS   = 1029983;
   localparam int CYCLE_YEARS  = 2820;
   localparam int LEAP_DIV     = 1028522;
   localparam int JAL_EPOCH    = 1948321;
   // start of cycle zero relative to the epoch, less one cycle
   localparam int EPOCH_LESS_CYCLE = JAL_EPOCH - 1 - CYCLE_DAYS;
   // day number of 1 Farvardin 475 minus one full cycle
   localparam int CYCLE_ORIGIN = 2121446 - CYCLE_DAYS;
   localparam int YEAR_BIAS    = CYCLE_YEARS - 474;

   // exact floor-division reciprocals: ceil(2^S / D)
   localparam logic [15:0] RECIP_100 = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
   localparam logic [20:0] RECIP_366 = 21'(((64'd1 << 29) + 64'd365) / 64'd366);
   localparam logic [14:0] RECIP_11  = 15'(((64'd1 << 18) + 64'd10) / 64'd11);
   localparam logic [14:0] RECIP_33  = 15'(((64'd1 << 20) + 64'd32) / 64'd33);
   localparam logic [9:0]  RECIP_31  = 10'(((64'd1 << 14) + 64'd30) / 64'd31);
   localparam logic [9:0]  RECIP_30  = 10'(((64'd1 << 14) + 64'd29) / 64'd30);
   localparam logic [25:0] RECIP_146097 =
      26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
   localparam logic [28:0] RECIP_1461001 =
      29'(((64'd1 << 49) + 64'd1461000) / 64'd1461001);
   // 80 * ceil(2^27 / 2447): folds the times-80 into the reciprocal
   localparam logic [22:0] MUL_80_2447 =
      23'(64'd80 * (((64'd1 << 27) + 64'd2446) / 64'd2447));

   // (367 * (m - 2 - 12a)) / 12 of the Gregorian day-number formula
   function automatic logic [8:0] greg_month_term(input logic [3:0] m);
      logic [8:0] t;
      case (m)
         4'd0:    t = 9'd305;
         4'd1:    t = 9'd336;
         4'd2:    t = 9'd367;
         4'd3:    t = 9'd30;
         4'd4:    t = 9'd61;
         4'd5:    t = 9'd91;
         4'd6:    t = 9'd122;
         4'd7:    t = 9'd152;
         4'd8:    t = 9'd183;
         4'd9:    t = 9'd214;
         4'd10:   t = 9'd244;
         4'd11:   t = 9'd275;
         4'd12:   t = 9'd305;
         4'd13:   t = 9'd336;
         4'd14:   t = 9'd367;
         4'd15:   t = 9'd397;
         default: t = 9'd0;
      endcase
      return t;
   endfunction

   // days in the Jalali year before the first of month m
   function automatic logic [8:0] jal_month_offset(input logic [3:0] m);
      logic [8:0] t;
      case (m)
         4'd1:    t = 9'd0;
         4'd2:    t = 9'd31;
         4'd3:    t = 9'd62;
         4'd4:    t = 9'd93;
         4'd5:    t = 9'd124;
         4'd6:    t = 9'd155;
         4'd7:    t = 9'd186;
         4'd8:    t = 9'd216;
         4'd9:    t = 9'd246;
         4'd10:   t = 9'd276;
         4'd11:   t = 9'd306;
         4'd12:   t = 9'd336;
         default: t = 9'd0;
      endcase
      return t;
   endfunction

   // (2447 * j) / 80
   function automatic logic [8:0] greg_day_offset(input logic [3:0] j);
      logic [8:0] t;
      case (j)
         4'd0:    t = 9'd0;
         4'd1:    t = 9'd30;
         4'd2:    t = 9'd61;
         4'd3:    t = 9'd91;
         4'd4:    t = 9'd122;
         4'd5:    t = 9'd152;
         4'd6:    t = 9'd183;
         4'd7:    t = 9'd214;
         4'd8:    t = 9'd244;
         4'd9:    t = 9'd275;
         4'd10:   t = 9'd305;
         4'd11:   t = 9'd336;
         4'd12:   t = 9'd367;
         4'd13:   t = 9'd397;
         4'd14:   t = 9'd428;
         4'd15:   t = 9'd458;
         default: t = 9'd0;
      endcase
      return t;
   endfunction

   // 33-year rule: year mod 33 values whose last month has 30 days
   function automatic logic jal_long_esfand(input logic [5:0] r);
      return r inside {6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30};
   endfunction

endpackage

// File: rtl/jgdc_req_if.sv
`timescale 1ns / 1ps
interface jgdc_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [13:0] in_year;
   logic [3:0]  in_month;
   logic [4:0]  in_day;

   modport source (output valid, op, in_year, in_month, in_day, input ready);
   modport sink (input valid, op, in_year, in_month, in_day, output ready);
endinterface

// File: rtl/jgdc_rsp_if.sv
`timescale 1ns / 1ps
interface jgdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] out_year;
   logic [3:0]  out_month;
   logic [4:0]  out_day;
   logic        invalid;

   modport source (output valid, out_year, out_month, out_day, invalid, input ready);
   modport sink (input valid, out_year, out_month, out_day, invalid, output ready);
endinterface

// File: rtl/jgdc_g2j.sv
`timescale 1ns / 1ps
module jgdc_g2j (
   input  logic                   clock,
   input  jgdc_pkg::stage_en_type en,
   input  logic [13:0]            in_year,
   input  logic [3:0]             in_month,
   input  logic [4:0]             in_day,
   output jgdc_pkg::result_type   result
);

   // stage 0: products of the Gregorian day-number formula
   logic        a_neg;
   logic [14:0] yp;
   logic [14:0] u;
   logic [30:0] q100_prod;
   logic [25:0] t1_in;
   logic [25:0] t1_ff;
   logic [7:0]  q100_ff;
   logic [8:0]  t2_ff;
   logic [4:0]  d_ff;

   // stage 1: day number
   logic [9:0]  t3_x3;
   logic [23:0] jdn_in;
   logic [23:0] jdn_ff [1:10];

   // stage 2: cycle index, stage 3: day in cycle
   logic [2:0]  qp_in;
   logic [2:0]  qp_ff [2:7];
   logic [19:0] cy_in;
   logic [19:0] cy_ff [3:4];

   // stages 4-7: year in cycle
   logic [40:0] a1_prod;
   logic [11:0] a1_ff [4:6];
   logic        last_ff [4:6];
   logic [8:0]  a2_in;
   logic [8:0]  a2_ff;
   logic [22:0] n2_in;
   logic [22:0] n2_ff;
   logic [2:0]  yq;
   logic [11:0] yc_in;
   logic [11:0] yc_ff;

   // stages 8-10: start of that year
   logic        full;
   logic [11:0] ey;
   logic [21:0] n_in;
   logic [21:0] n_ff;
   logic [20:0] e365_ff [8:9];
   logic [2:0]  c2_ff [8:9];
   logic [15:0] yrpre_in;
   logic [15:0] yrpre_ff [8:12];
   logic [28:0] t_prod;
   logic [9:0]  t_ff;
   logic [23:0] start_in;
   logic [23:0] start_ff;

   // stages 11-13: month and day
   logic [8:0]  yd_in;
   logic [8:0]  yd_ff [11:12];
   logic [18:0] mo_prod;
   logic [3:0]  mo_in;
   logic [3:0]  mo_ff;
   logic signed [15:0] yr_s;
   jgdc_pkg::result_type res_in;
   jgdc_pkg::result_type res_ff;

   assign a_neg     = (in_month <= 4'd2);
   assign yp        = 15'({1'b0, in_year}) + 15'd4800 - 15'(a_neg);
   assign u         = 15'({1'b0, in_year}) + 15'd4900 - 15'(a_neg);
   assign t1_in     = 26'(yp) * 26'd1461;
   assign q100_prod = 31'(u) * 31'(jgdc_pkg::RECIP_100);

   assign t3_x3  = 10'(q100_ff) * 10'd3;
   assign jdn_in = 24'(t1_ff[25:2]) + 24'(t2_ff) + 24'(d_ff) - 24'(t3_x3[9:2])
                   - 24'd32075;

   always_comb begin
      qp_in = '0;
      for (int k = 1; k <= 6; k++) begin
         if (jdn_ff[1] >= 24'(jgdc_pkg::CYCLE_ORIGIN + k * jgdc_pkg::CYCLE_DAYS)) begin
            qp_in = 3'(k);
         end
      end
   end

   assign cy_in = 20'(jdn_ff[2] - 24'(jgdc_pkg::CYCLE_ORIGIN)
                      - 24'(qp_ff[2]) * 24'(jgdc_pkg::CYCLE_DAYS));

   assign a1_prod = 41'(cy_ff[3]) * 41'(jgdc_pkg::RECIP_366);
   assign a2_in   = 9'(cy_ff[4] - 20'(a1_ff[4]) * 20'd366);
   assign n2_in   = 23'(a1_ff[5]) * 23'd2134 + 23'(a2_ff) * 23'd2816 + 23'd2815;

   always_comb begin
      yq = '0;
      for (int k = 1; k <= 6; k++) begin
         if (n2_ff >= 23'(k * jgdc_pkg::LEAP_DIV)) begin
            yq = 3'(k);
         end
      end
      // last day of a cycle closes year 2820
      if (last_ff[6]) begin
         yc_in = 12'(jgdc_pkg::CYCLE_YEARS);
      end else begin
         yc_in = 12'(yq) + a1_ff[6] + 12'd1;
      end
   end

   assign full     = (yc_ff == 12'(jgdc_pkg::CYCLE_YEARS));
   assign ey       = 12'd474 + (full ? 12'd0 : yc_ff);
   assign n_in     = 22'(ey) * 22'd682 - 22'd110;
   assign yrpre_in = 16'(yc_ff) + 16'(qp_ff[7]) * 16'(jgdc_pkg::CYCLE_YEARS)
                     - 16'(jgdc_pkg::YEAR_BIAS);

   assign t_prod   = 29'(n_ff[21:8]) * 29'(jgdc_pkg::RECIP_11);
   assign start_in = 24'(t_ff) + 24'(e365_ff[9])
                     + 24'(c2_ff[9]) * 24'(jgdc_pkg::CYCLE_DAYS)
                     + 24'(jgdc_pkg::EPOCH_LESS_CYCLE + 1);

   assign yd_in = 9'(jdn_ff[10] - start_ff + 24'd1);

   always_comb begin
      if (yd_ff[11] <= 9'd186) begin
         mo_prod = 19'(yd_ff[11] - 9'd1) * 19'(jgdc_pkg::RECIP_31);
      end else begin
         mo_prod = 19'(yd_ff[11] - 9'd7) * 19'(jgdc_pkg::RECIP_30);
      end
      mo_in = 4'(mo_prod[18:14]) + 4'd1;
   end

   always_comb begin
      yr_s              = signed'(yrpre_ff[12]);
      res_in.out_year   = (yr_s <= 16'sd0) ? 15'(yr_s - 16'sd1) : 15'(yr_s);
      res_in.out_month  = mo_ff;
      res_in.out_day    = 5'(yd_ff[12] - jgdc_pkg::jal_month_offset(mo_ff));
      res_in.invalid    = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t1_ff   <= t1_in;
         q100_ff <= q100_prod[29:22];
         t2_ff   <= jgdc_pkg::greg_month_term(in_month);
         d_ff    <= in_day;
      end
      if (en[1]) begin
         jdn_ff[1] <= jdn_in;
      end
      for (int k = 2; k <= 10; k++) begin
         if (en[k]) begin
            jdn_ff[k] <= jdn_ff[k-1];
         end
      end
      if (en[2]) begin
         qp_ff[2] <= qp_in;
      end
      for (int k = 3; k <= 7; k++) begin
         if (en[k]) begin
            qp_ff[k] <= qp_ff[k-1];
         end
      end
      if (en[3]) begin
         cy_ff[3] <= cy_in;
      end
      if (en[4]) begin
         cy_ff[4]   <= cy_ff[3];
         a1_ff[4]   <= a1_prod[40:29];
         last_ff[4] <= (cy_ff[3] == 20'(jgdc_pkg::CYCLE_DAYS - 1));
      end
      for (int k = 5; k <= 6; k++) begin
         if (en[k]) begin
            a1_ff[k]   <= a1_ff[k-1];
            last_ff[k] <= last_ff[k-1];
         end
      end
      if (en[5]) begin
         a2_ff <= a2_in;
      end
      if (en[6]) begin
         n2_ff <= n2_in;
      end
      if (en[7]) begin
         yc_ff <= yc_in;
      end
      if (en[8]) begin
         n_ff        <= n_in;
         e365_ff[8]  <= 21'(ey - 12'd1) * 21'd365;
         c2_ff[8]    <= qp_ff[7] + 3'(full);
         yrpre_ff[8] <= yrpre_in;
      end
      if (en[9]) begin
         t_ff       <= t_prod[27:18];
         e365_ff[9] <= e365_ff[8];
         c2_ff[9]   <= c2_ff[8];
      end
      for (int k = 9; k <= 12; k++) begin
         if (en[k]) begin
            yrpre_ff[k] <= yrpre_ff[k-1];
         end
      end
      if (en[10]) begin
         start_ff <= start_in;
      end
      if (en[11]) begin
         yd_ff[11] <= yd_in;
      end
      if (en[12]) begin
         yd_ff[12] <= yd_ff[11];
         mo_ff     <= mo_in;
      end
      if (en[13]) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// File: rtl/jgdc_j2g.sv
`timescale 1ns / 1ps
module jgdc_j2g (
   input  logic                   clock,
   input  jgdc_pkg::stage_en_type en,
   input  logic [13:0]            in_year,
   input  logic [3:0]             in_month,
   input  logic [4:0]             in_day,
   input  logic [13:0]            min_year,
   input  logic [13:0]            max_year,
   output jgdc_pkg::result_type   result
);

   // stage 0: range checks, year / 33 and 2820-year split
   logic [28:0] q33_prod;
   logic [14:0] bp_in;
   logic [2:0]  qp_in;
   logic        ok_in;
   logic [8:0]  q33_ff;
   logic [13:0] y_ff;
   logic [14:0] bp_ff;
   logic [2:0]  qp_ff [0:3];
   logic [3:0]  m_ff [0:1];
   logic [4:0]  d_ff [0:3];
   logic        ok_ff [0:1];
   logic        long_ff [0:1];

   // stage 1: remainders
   logic [5:0]  r33_ff;
   logic [11:0] r2820_ff;

   // stages 2-4: day number
   logic [11:0] ey;
   logic [21:0] n_ff;
   logic [20:0] e365_ff [2:3];
   logic [8:0]  md_ff [2:3];
   logic        valid_ff [2:10];
   logic [28:0] t_prod;
   logic [9:0]  t_ff;
   logic [23:0] jdn_in;
   logic [23:0] jdn_ff;

   // stages 5-11: Gregorian date from day number
   logic [22:0] l_in;
   logic [22:0] l_ff;
   logic [50:0] n4_prod;
   logic [7:0]  nq_ff [5:10];
   logic [25:0] nback;
   logic [15:0] l2_ff [6:8];
   logic [27:0] p_ff;
   logic [56:0] i_prod;
   logic [6:0]  i_ff [8:10];
   logic [17:0] i1461;
   logic [8:0]  l3_in;
   logic [8:0]  l3_ff [9:10];
   logic [31:0] j_prod;
   logic [3:0]  j_ff;
   logic        jq;
   jgdc_pkg::result_type res_in;
   jgdc_pkg::result_type res_ff [11:13];

   assign q33_prod = 29'(in_year) * 29'(jgdc_pkg::RECIP_33);
   assign bp_in    = 15'(in_year) + 15'(jgdc_pkg::YEAR_BIAS);

   always_comb begin
      qp_in = '0;
      for (int k = 1; k <= 6; k++) begin
         if (bp_in >= 15'(k * jgdc_pkg::CYCLE_YEARS)) begin
            qp_in = 3'(k);
         end
      end
      // day 30 of the last month waits for the leap test
      ok_in = (in_year >= min_year) && (in_year <= max_year)
              && (in_month >= 4'd1) && (in_month <= 4'd12)
              && (in_day != 5'd0)
              && ((in_day != 5'd31) || (in_month <= 4'd6));
   end

   assign ey     = 12'd474 + r2820_ff;
   assign t_prod = 29'(n_ff[21:8]) * 29'(jgdc_pkg::RECIP_11);
   assign jdn_in = 24'(d_ff[3]) + 24'(md_ff[3]) + 24'(t_ff) + 24'(e365_ff[3])
                   + 24'(qp_ff[3]) * 24'(jgdc_pkg::CYCLE_DAYS)
                   + 24'(jgdc_pkg::EPOCH_LESS_CYCLE);

   assign l_in    = 23'(jdn_ff + 24'd68569);
   assign n4_prod = 51'({l_in, 2'b00}) * 51'(jgdc_pkg::RECIP_146097);
   assign nback   = (26'(nq_ff[5]) * 26'd146097 + 26'd3) >> 2;
   assign i_prod  = 57'(p_ff) * 57'(jgdc_pkg::RECIP_1461001);
   assign i1461   = 18'(i_ff[8]) * 18'd1461;
   assign l3_in   = 9'(17'(l2_ff[8]) - 17'(i1461[17:2]) + 17'd31);
   assign j_prod  = 32'(l3_ff[9]) * 32'(jgdc_pkg::MUL_80_2447);

   always_comb begin
      jq = (j_ff >= 4'd11);
      if (valid_ff[10]) begin
         res_in.out_year  = 15'(16'(nq_ff[10]) * 16'd100 - 16'd4900
                                + 16'(i_ff[10]) + 16'(jq));
         res_in.out_month = 4'(j_ff + 4'd2 - (jq ? 4'd12 : 4'd0));
         res_in.out_day   = 5'(l3_ff[10] - jgdc_pkg::greg_day_offset(j_ff));
         res_in.invalid   = 1'b0;
      end else begin
         res_in = '{out_year: '0, out_month: '0, out_day: '0, invalid: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         q33_ff     <= q33_prod[28:20];
         y_ff       <= in_year;
         bp_ff      <= bp_in;
         qp_ff[0]   <= qp_in;
         m_ff[0]    <= in_month;
         d_ff[0]    <= in_day;
         ok_ff[0]   <= ok_in;
         long_ff[0] <= (in_month == 4'd12) && (in_day == 5'd30);
      end
      if (en[1]) begin
         r33_ff     <= 6'(y_ff - 14'(q33_ff) * 14'd33);
         r2820_ff   <= 12'(bp_ff - 15'(qp_ff[0]) * 15'(jgdc_pkg::CYCLE_YEARS));
         m_ff[1]    <= m_ff[0];
         ok_ff[1]   <= ok_ff[0];
         long_ff[1] <= long_ff[0];
      end
      for (int k = 1; k <= 3; k++) begin
         if (en[k]) begin
            qp_ff[k] <= qp_ff[k-1];
            d_ff[k]  <= d_ff[k-1];
         end
      end
      if (en[2]) begin
         valid_ff[2] <= ok_ff[1] && (!long_ff[1] || jgdc_pkg::jal_long_esfand(r33_ff));
         n_ff        <= 22'(ey) * 22'd682 - 22'd110;
         e365_ff[2]  <= 21'(ey - 12'd1) * 21'd365;
         md_ff[2]    <= jgdc_pkg::jal_month_offset(m_ff[1]);
      end
      for (int k = 3; k <= 10; k++) begin
         if (en[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
      if (en[3]) begin
         t_ff       <= t_prod[27:18];
         e365_ff[3] <= e365_ff[2];
         md_ff[3]   <= md_ff[2];
      end
      if (en[4]) begin
         jdn_ff <= jdn_in;
      end
      if (en[5]) begin
         l_ff     <= l_in;
         nq_ff[5] <= n4_prod[50:43];
      end
      for (int k = 6; k <= 10; k++) begin
         if (en[k]) begin
            nq_ff[k] <= nq_ff[k-1];
         end
      end
      if (en[6]) begin
         l2_ff[6] <= 16'(l_ff - 23'(nback));
      end
      if (en[7]) begin
         p_ff     <= 28'(l2_ff[6] + 16'd1) * 28'd4000;
         l2_ff[7] <= l2_ff[6];
      end
      if (en[8]) begin
         i_ff[8]  <= i_prod[55:49];
         l2_ff[8] <= l2_ff[7];
      end
      if (en[9]) begin
         i_ff[9]  <= i_ff[8];
         l3_ff[9] <= l3_in;
      end
      if (en[10]) begin
         i_ff[10]  <= i_ff[9];
         l3_ff[10] <= l3_ff[9];
         j_ff      <= j_prod[30:27];
      end
      if (en[11]) begin
         res_ff[11] <= res_in;
      end
      for (int k = 12; k <= 13; k++) begin
         if (en[k]) begin
            res_ff[k] <= res_ff[k-1];
         end
      end
   end

   assign result = res_ff[13];

endmodule

// File: rtl/jalali_gregorian_date_convert.sv
// Date converter, Gregorian <-> Jalali, one request per cycle unless the result stalls.
// Datapath: 14 register stages (one reciprocal multiply per constant division).
// Throughput: one request per cycle; a stalled result holds only the stages behind it.
// Reset (synchronous, active high) empties the pipeline and loads the year limits
// with 1131 and 10000.
`timescale 1ns / 1ps
module jalali_gregorian_date_convert (
   input  logic              clock,
   input  logic              reset,
   jgdc_req_if.sink          req_chan,
   jgdc_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [13:0]       csr_write_data
);

   localparam int LAST = jgdc_pkg::NUM_STAGES - 1;

   jgdc_pkg::stage_en_type en;
   logic                   valid_ff [0:LAST];
   jgdc_pkg::op_type       op_ff [0:LAST];
   logic [13:0]            min_year_ff;
   logic [13:0]            max_year_ff;
   jgdc_pkg::result_type   g_result;
   jgdc_pkg::result_type   j_result;
   jgdc_pkg::result_type   result;

   // a stage loads when it is empty or its request moves on
   always_comb begin
      en[LAST] = !valid_ff[LAST] || rsp_chan.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k <= LAST; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         op_ff[0] <= jgdc_pkg::op_type'(req_chan.op);
      end
      for (int k = 1; k <= LAST; k++) begin
         if (en[k]) begin
            op_ff[k] <= op_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff <= jgdc_pkg::MIN_YEAR_RESET;
         max_year_ff <= jgdc_pkg::MAX_YEAR_RESET;
      end else if (csr_write_enable) begin
         case (jgdc_pkg::csr_index_type'(csr_index))
            jgdc_pkg::CSR_MIN_JALALI_YEAR: min_year_ff <= csr_write_data;
            jgdc_pkg::CSR_MAX_JALALI_YEAR: max_year_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   jgdc_g2j u_g2j (
      .clock    (clock),
      .en       (en),
      .in_year  (req_chan.in_year),
      .in_month (req_chan.in_month),
      .in_day   (req_chan.in_day),
      .result   (g_result)
   );

   jgdc_j2g u_j2g (
      .clock    (clock),
      .en       (en),
      .in_year  (req_chan.in_year),
      .in_month (req_chan.in_month),
      .in_day   (req_chan.in_day),
      .min_year (min_year_ff),
      .max_year (max_year_ff),
      .result   (j_result)
   );

   assign result = (op_ff[LAST] == jgdc_pkg::OP_JAL_TO_GREG) ? j_result : g_result;

   assign req_chan.ready     = en[0];
   assign rsp_chan.valid     = valid_ff[LAST];
   assign rsp_chan.out_year  = result.out_year;
   assign rsp_chan.out_month = result.out_month;
   assign rsp_chan.out_day   = result.out_day;
   assign rsp_chan.invalid   = result.invalid;

endmodule

// File: rtl/jgdc_checker.sv
`timescale 1ns / 1ps
`include "jalali_gregorian_date_convert_defines.svh"
module jgdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [14:0] out_year,
   input logic [3:0]  out_month,
   input logic [4:0]  out_day,
   input logic        invalid
);

   `JGDC_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

   `JGDC_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_year) && $stable(out_month) && $stable(out_day) && $stable(invalid), "stalled result changed")

   `JGDC_ASSERT(a_invalid_zero, clock, reset, rsp_valid && invalid |-> out_year == 15'd0 && out_month == 4'd0 && out_day == 5'd0, "rejected request carries a date")

   `JGDC_ASSERT(a_date_legal, clock, reset, rsp_valid && !invalid |-> out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1, "converted date out of range")

endmodule

bind jalali_gregorian_date_convert jgdc_checker u_jgdc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_year  (rsp_chan.out_year),
   .out_month (rsp_chan.out_month),
   .out_day   (rsp_chan.out_day),
   .invalid   (rsp_chan.invalid)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

   typedef struct {
      jgdc_pkg::op_type op;
      logic [13:0]      year;
      logic [3:0]       month;
      logic [4:0]       day;
   } date_req_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic [13:0] csr_write_data;

   jgdc_req_if req_chan();
   jgdc_rsp_if rsp_chan();

   jalali_gregorian_date_convert DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   date_req_type         pending_dates[$];
   jgdc_pkg::result_type converted_dates[$];
   logic [13:0] year_floor, year_ceiling;
   int errors, num_g2j, num_j2g, num_rejected, accepted_rsp;
   int send_gap, recv_gap, hold_left, idle_cycles;
   bit long_hold_done, no_idle;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---- calendar arithmetic ----
   function automatic longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) < 0) q--;
      return q;
   endfunction

   function automatic longint fmod(longint a, longint b);
      longint r;
      r = a % b;
      if (r < 0) r += b;
      return r;
   endfunction

   function automatic longint jalali_day_number(longint y, longint m, longint d);
      longint base, ey, md;
      base = y - ((y >= 0) ? 474 : 473);
      ey = 474 + fmod(base, 2820);
      md = (m <= 7) ? (m - 1) * 31 : (m - 1) * 30 + 6;
      return d + md + (ey * 682 - 110) / 2816 + (ey - 1) * 365
         + fdiv(base, 2820) * 1029983 + 1948320;
   endfunction

   function automatic longint gregorian_day_number(longint y, longint m, longint d);
      longint a;
      a = (m - 14) / 12;
      return (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
         - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
   endfunction

   function automatic int esfand_length(longint y);
      longint r;
      r = y % 33;
      return (r == 1 || r == 5 || r == 9 || r == 13 || r == 17 || r == 22 ||
              r == 26 || r == 30) ? 30 : 29;
   endfunction

   function automatic int jalali_month_length(longint m, longint y);
      if (m <= 6) return 31;
      if (m <= 11) return 30;
      return esfand_length(y);
   endfunction

   function automatic jgdc_pkg::result_type convert_date(date_req_type r, logic [13:0] lo,
                                                         logic [13:0] hi);
      jgdc_pkg::result_type res;
      longint y, m, d, jdn, dep, cyc, cy, yc, yr, yd, mo, l, n, i, j;
      y = r.year; m = r.month; d = r.day;
      res = '0;
      if (r.op == jgdc_pkg::OP_GREG_TO_JAL) begin
         jdn = gregorian_day_number(y, m, d);
         dep = jdn - jalali_day_number(475, 1, 1);
         cyc = fdiv(dep, 1029983);
         cy = fmod(dep, 1029983);
         if (cy == 1029982) yc = 2820;
         else yc = (2134 * (cy / 366) + 2816 * (cy % 366) + 2815) / 1028522
                   + cy / 366 + 1;
         yr = yc + 2820 * cyc + 474;
         if (yr <= 0) yr--;
         yd = jdn - jalali_day_number(yr, 1, 1) + 1;
         mo = (yd <= 186) ? (yd - 1) / 31 + 1 : (yd - 7) / 30 + 1;
         res.out_year = yr[14:0];
         res.out_month = mo[3:0];
         res.out_day = 5'(jdn - jalali_day_number(yr, mo, 1) + 1);
      end else if (r.year < lo || r.year > hi || m < 1 || m > 12 || d < 1 ||
                   d > jalali_month_length(m, y)) begin
         res.invalid = 1'b1;
      end else begin
         jdn = jalali_day_number(y, m, d);
         l = jdn + 68569;
         n = (4 * l) / 146097;
         l = l - (146097 * n + 3) / 4;
         i = (4000 * (l + 1)) / 1461001;
         l = l - (1461 * i) / 4 + 31;
         j = (80 * l) / 2447;
         res.out_day = 5'(l - (2447 * j) / 80);
         l = j / 11;
         res.out_month = 4'(j + 2 - 12 * l);
         res.out_year = 15'(100 * (n - 49) + i + l);
      end
      return res;
   endfunction

   function automatic int pick_gap();
      if (no_idle || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---- request driver ----
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            date_req_type r;
            r.op = jgdc_pkg::op_type'(req_chan.op);
            r.year = req_chan.in_year;
            r.month = req_chan.in_month;
            r.day = req_chan.in_day;
            converted_dates.push_back(convert_date(r, year_floor, year_ceiling));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0 || pending_dates.size() == 0) begin
               req_chan.valid <= 1'b0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               date_req_type r;
               r = pending_dates.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.op <= r.op;
               req_chan.in_year <= r.year;
               req_chan.in_month <= r.month;
               req_chan.in_day <= r.day;
               send_gap <= pick_gap();
            end
         end
      end
   end

   // ---- result monitor ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            jgdc_pkg::result_type exp_res;
            accepted_rsp <= accepted_rsp + 1;
            if (converted_dates.size() == 0) begin
               $error("unexpected result year=%0d", rsp_chan.out_year);
               errors++;
            end else begin
               exp_res = converted_dates.pop_front();
               if (rsp_chan.out_year !== exp_res.out_year) begin
                  $error("out_year exp %0d got %0d", exp_res.out_year, rsp_chan.out_year);
                  errors++;
               end
               if (rsp_chan.out_month !== exp_res.out_month) begin
                  $error("out_month exp %0d got %0d", exp_res.out_month,
                         rsp_chan.out_month);
                  errors++;
               end
               if (rsp_chan.out_day !== exp_res.out_day) begin
                  $error("out_day exp %0d got %0d", exp_res.out_day, rsp_chan.out_day);
                  errors++;
               end
               if (rsp_chan.invalid !== exp_res.invalid) begin
                  $error("invalid exp %0d got %0d", exp_res.invalid, rsp_chan.invalid);
                  errors++;
               end
            end
         end
         // one long back-pressure stretch so the pipeline fills and stalls input
         if (!long_hold_done && accepted_rsp == 300) begin
            long_hold_done <= 1'b1;
            hold_left <= 200;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            recv_gap <= pick_gap();
         end
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic add_date(jgdc_pkg::op_type op, int y, int m, int d);
      date_req_type r;
      r.op = op; r.year = y[13:0]; r.month = m[3:0]; r.day = d[4:0];
      pending_dates.push_back(r);
      if (op == jgdc_pkg::OP_GREG_TO_JAL) num_g2j++;
      else begin
         num_j2g++;
         if (convert_date(r, year_floor, year_ceiling).invalid) num_rejected++;
      end
   endtask

   task automatic write_limit(jgdc_pkg::csr_index_type idx, int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[13:0];
      if (idx == jgdc_pkg::CSR_MIN_JALALI_YEAR) year_floor = value[13:0];
      else year_ceiling = value[13:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // sample away from the rising edge so driver and monitor updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_dates.size() != 0 || req_chan.valid || converted_dates.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic add_random_dates(int count);
      int y, m;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                              : $urandom_range(1, 10000);
               add_date(jgdc_pkg::OP_GREG_TO_JAL, y, $urandom_range(1, 12),
                        $urandom_range(1, 28));
            end
            4, 5, 6, 7: begin
               if (year_floor <= year_ceiling)
                  y = $urandom_range(year_floor, year_ceiling);
               else
                  y = $urandom_range(1, 10000);
               m = $urandom_range(1, 12);
               add_date(jgdc_pkg::OP_JAL_TO_GREG, y, m,
                        $urandom_range(1, jalali_month_length(m, y)));
            end
            default:
               add_date(jgdc_pkg::op_type'($urandom_range(0, 1)), $urandom_range(0, 16383),
                        $urandom_range(0, 15), $urandom_range(0, 31));
         endcase
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op = jgdc_pkg::OP_GREG_TO_JAL;
      req_chan.in_year = '0;
      req_chan.in_month = '0;
      req_chan.in_day = '0;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = jgdc_pkg::CSR_MIN_JALALI_YEAR;
      csr_write_data = '0;
      year_floor = jgdc_pkg::MIN_YEAR_RESET;
      year_ceiling = jgdc_pkg::MAX_YEAR_RESET;
      errors = 0; accepted_rsp = 0; idle_cycles = 0;
      num_g2j = 0; num_j2g = 0; num_rejected = 0;
      long_hold_done = 1'b0; no_idle = 1'b0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, spill-over Gregorian dates, Jalali checks
      add_date(jgdc_pkg::OP_GREG_TO_JAL, 0, 0, 0);
      add_date(jgdc_pkg::OP_GREG_TO_JAL, 16383, 15, 31);
      add_date(jgdc_pkg::OP_GREG_TO_JAL, 1, 1, 1);
      add_date(jgdc_pkg::OP_GREG_TO_JAL, 10000, 12, 31);
      add_date(jgdc_pkg::OP_GREG_TO_JAL, 2000, 2, 29);
      add_date(jgdc_pkg::OP_GREG_TO_JAL, 1900, 2, 30);
      add_date(jgdc_pkg::OP_GREG_TO_JAL, 2024, 13, 0);
      add_date(jgdc_pkg::OP_GREG_TO_JAL, 622, 3, 21);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1131, 1, 1);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1130, 12, 29);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 10000, 12, 30);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 10001, 1, 1);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1403, 12, 30);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1402, 12, 30);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1402, 12, 29);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1400, 0, 5);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1400, 13, 5);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1400, 5, 0);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1400, 6, 31);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1400, 7, 31);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 16383, 15, 31);
      add_random_dates(160);
      wait_drained();

      write_limit(jgdc_pkg::CSR_MIN_JALALI_YEAR, 1);
      write_limit(jgdc_pkg::CSR_MAX_JALALI_YEAR, 10000);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 1, 1, 1);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 0, 1, 1);
      add_random_dates(200);
      wait_drained();

      // min above max: every Jalali request is rejected
      no_idle = 1'b1;
      write_limit(jgdc_pkg::CSR_MIN_JALALI_YEAR, 10000);
      write_limit(jgdc_pkg::CSR_MAX_JALALI_YEAR, 1);
      add_random_dates(170);
      wait_drained();

      no_idle = 1'b0;
      write_limit(jgdc_pkg::CSR_MIN_JALALI_YEAR, 5000);
      write_limit(jgdc_pkg::CSR_MAX_JALALI_YEAR, 5000);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 4999, 1, 1);
      add_date(jgdc_pkg::OP_JAL_TO_GREG, 5001, 1, 1);
      add_random_dates(170);
      wait_drained();

      write_limit(jgdc_pkg::CSR_MIN_JALALI_YEAR, 1);
      write_limit(jgdc_pkg::CSR_MAX_JALALI_YEAR, 1);
      add_random_dates(170);
      wait_drained();

      repeat (30) @(posedge clock);
      $display("Converted %0d Gregorian and %0d Jalali dates (%0d Jalali rejected)",
               num_g2j, num_j2g, num_rejected);
      $display("over five year-limit settings, with random stalls and one long hold");
      if (errors == 0 && converted_dates.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
